// ===== src/phrd_pkg.sv =====
// ----------------------------------------------------------------------------
// phrd_pkg
// Shared widths, codes and types of the PPG heart rate detector.
// ----------------------------------------------------------------------------
package phrd_pkg;

    localparam int IR_W       = 18;
    localparam int TIME_W     = 32;
    localparam int THR_W      = 18;
    localparam int IVL_W      = 12;
    localparam int DC_W       = 19;
    localparam int AC_W       = 20;
    localparam int WAVE_W     = 14;
    localparam int RATE_W     = 16;
    localparam int DIV_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 18;
    localparam int S_DATA_W   = 56;
    localparam int M_DATA_W   = 40;

    localparam logic [RATE_W-1:0]      RATE_NUMERATOR = 16'd60000;
    localparam logic signed [AC_W-1:0] WAVE_LIMIT     = 20'sd4096;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FINGER_THR = 2'd0,
        REG_AMP_THR    = 2'd1,
        REG_MIN_IVL    = 2'd2,
        REG_MAX_IVL    = 2'd3
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DC,
        ST_BEAT,
        ST_SUM,
        ST_DIV_MEAN,
        ST_DIV_RATE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic             clear;
        logic             push;
        logic [IVL_W-1:0] data;
    } ring_cmd_t;

endpackage

// ===== src/phrd_div.sv =====
// ----------------------------------------------------------------------------
// phrd_div
// Restoring divider, one quotient bit per cycle, shared by the mean and
// rate calculations.
// ----------------------------------------------------------------------------
module phrd_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [phrd_pkg::DIV_W-1:0] dividend,
    input  logic [phrd_pkg::DIV_W-1:0] divisor,
    output logic                       done,
    output logic [phrd_pkg::DIV_W-1:0] quotient
);
    import phrd_pkg::*;

    localparam int CNT_W = $clog2(DIV_W);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DIV_W:0]   rem_reg;
    logic [DIV_W:0]   rem_next;
    logic [DIV_W-1:0] quo_reg;
    logic [DIV_W-1:0] quo_next;
    logic [DIV_W-1:0] dvs_reg;
    logic [DIV_W:0]   shifted;
    logic [DIV_W:0]   diff;

    always_comb
    begin
        shifted = {rem_reg[DIV_W-1:0], quo_reg[DIV_W-1]};
        diff    = shifted - {1'b0, dvs_reg};
        if (!diff[DIV_W])
        begin
            rem_next = diff;
            quo_next = {quo_reg[DIV_W-2:0], 1'b1};
        end
        else
        begin
            rem_next = shifted;
            quo_next = {quo_reg[DIV_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIV_W - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== src/phrd_ring.sv =====
// ----------------------------------------------------------------------------
// phrd_ring
// Ring of the most recent beat intervals with write pointer and fill count.
// ----------------------------------------------------------------------------
module phrd_ring #(
    parameter int SLOTS  = 4,
    parameter int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1,
    parameter int CNT_W  = $clog2(SLOTS + 1)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  phrd_pkg::ring_cmd_t        cmd,
    input  logic [SLOT_W-1:0]          rd_idx,
    output logic [phrd_pkg::IVL_W-1:0] rd_data,
    output logic [CNT_W-1:0]           count
);
    import phrd_pkg::*;

    logic [IVL_W-1:0]  store_reg [SLOTS];
    logic [SLOT_W-1:0] slot_reg;
    logic [SLOT_W-1:0] slot_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    always_comb
    begin
        slot_next  = slot_reg;
        count_next = count_reg;
        if (cmd.clear)
        begin
            slot_next  = '0;
            count_next = '0;
        end
        else if (cmd.push)
        begin
            slot_next = (slot_reg == SLOT_W'(SLOTS - 1)) ? '0 : slot_reg + 1'b1;
            if (count_reg != CNT_W'(SLOTS))
                count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            slot_reg  <= slot_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push && !cmd.clear)
            store_reg[slot_reg] <= cmd.data;
    end

    assign rd_data = store_reg[rd_idx];
    assign count   = count_reg;

endmodule

// ===== src/ppg_heart_rate_detector.sv =====
// ----------------------------------------------------------------------------
// ppg_heart_rate_detector
// Finger detect, DC removal, threshold beat detection and heart rate from
// the mean of the last beat intervals.
// ----------------------------------------------------------------------------
// Channel   Dir  Signals                         Beat
// s_*       in   s_tvalid s_tready s_tdata[55:0]  one IR sample with timestamp
// m_*       out  m_tvalid m_tready m_tdata[39:0]  one detector result
// cfg_*     in   cfg_we cfg_index cfg_data        one register write
//
// Finger, no rate update: idle, DC, beat and done states; no finger: idle, DC, done.
// A rate update adds a summing pass over the stored intervals and two divider
// passes, mean then rate (a zero mean skips the second).
// A full result register holds the sequencer until m_tready; s_tready is
// low while a sample is in work. Reset is asynchronous; no clearing pass.
// ----------------------------------------------------------------------------
module ppg_heart_rate_detector #(
    parameter int INTERVAL_SLOTS = 4
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // ir_sample[17:0], sample_time_ms[49:18], zero pad
    input  logic [phrd_pkg::S_DATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // finger_present[0], beat_detected[1], rate_updated[2],
    // heart_rate[18:3], wave_value[32:19], zero pad
    output logic [phrd_pkg::M_DATA_W-1:0]   m_tdata,
    input  logic                            cfg_we,
    input  logic [phrd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [phrd_pkg::CFG_DATA_W-1:0] cfg_data
);
    import phrd_pkg::*;

    localparam int SLOT_W = (INTERVAL_SLOTS > 1) ? $clog2(INTERVAL_SLOTS) : 1;
    localparam int CNT_W  = $clog2(INTERVAL_SLOTS + 1);
    localparam int SUM_W  = IVL_W + $clog2(INTERVAL_SLOTS);

    state_t state_reg;
    state_t state_next;

    logic [THR_W-1:0]  finger_thr_reg;
    logic [THR_W-1:0]  amp_thr_reg;
    logic [IVL_W-1:0]  min_ivl_reg;
    logic [IVL_W-1:0]  max_ivl_reg;

    logic [IR_W-1:0]   in_ir_reg;
    logic [TIME_W-1:0] in_time_reg;

    logic signed [DC_W-1:0] dc_reg;
    logic signed [AC_W-1:0] prev_ac_reg;
    logic [TIME_W-1:0]      last_time_reg;
    logic                   armed_reg;
    logic [RATE_W-1:0]      rate_reg;

    logic              finger_reg;
    logic              beat_reg;
    logic              upd_reg;
    logic [WAVE_W-1:0] wave_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [SLOT_W-1:0] k_reg;

    logic              m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;

    logic                   no_finger;
    logic signed [AC_W-1:0] ir_s;
    logic signed [AC_W-1:0] base;
    logic signed [AC_W-1:0] delta;
    logic signed [AC_W-1:0] dc_upd;
    logic signed [AC_W-1:0] ac;
    logic signed [AC_W-1:0] amp_s;
    logic                   crossing;
    logic [TIME_W-1:0]      dt;
    logic                   in_range;
    logic                   rate_push;
    logic [WAVE_W-1:0]      wave_calc;
    logic [SUM_W-1:0]       sum_add;
    logic                   sum_last;
    logic                   out_free;
    logic                   out_load;

    ring_cmd_t         ring_cmd;
    logic [IVL_W-1:0]  ring_data;
    logic [CNT_W-1:0]  ring_count;

    logic              div_start;
    logic [DIV_W-1:0]  div_dividend;
    logic [DIV_W-1:0]  div_divisor;
    logic              div_done;
    logic [DIV_W-1:0]  div_quot;

    phrd_ring #(
        .SLOTS  (INTERVAL_SLOTS),
        .SLOT_W (SLOT_W),
        .CNT_W  (CNT_W)
    ) u_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (ring_cmd),
        .rd_idx  (k_reg),
        .rd_data (ring_data),
        .count   (ring_count)
    );

    phrd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    // datapath
    always_comb
    begin
        no_finger = in_ir_reg < finger_thr_reg;
        ir_s      = $signed({{(AC_W - IR_W){1'b0}}, in_ir_reg});
        base      = (dc_reg == '0) ? ir_s : AC_W'(dc_reg);
        delta     = ir_s - base;
        dc_upd    = base + (delta >>> 5);
        ac        = ir_s - AC_W'(dc_reg);
        amp_s     = $signed({{(AC_W - THR_W){1'b0}}, amp_thr_reg});
        crossing  = (ac > amp_s) && (prev_ac_reg <= amp_s);
        dt        = in_time_reg - last_time_reg;
        in_range  = (dt >= TIME_W'(min_ivl_reg)) && (dt <= TIME_W'(max_ivl_reg));
        rate_push = crossing && armed_reg && in_range;
        if (ac > WAVE_LIMIT)
            wave_calc = WAVE_W'(WAVE_LIMIT);
        else if (ac < -WAVE_LIMIT)
            wave_calc = WAVE_W'(-WAVE_LIMIT);
        else
            wave_calc = WAVE_W'(ac);
        sum_add  = sum_reg + SUM_W'(ring_data);
        sum_last = (CNT_W'(k_reg) + 1'b1) == ring_count;
        out_free = !m_tvalid_reg || m_tready;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (s_tvalid)
                    state_next = ST_DC;
            ST_DC:
                state_next = no_finger ? ST_DONE : ST_BEAT;
            ST_BEAT:
                state_next = rate_push ? ST_SUM : ST_DONE;
            ST_SUM:
                if (sum_last)
                    state_next = ST_DIV_MEAN;
            ST_DIV_MEAN:
                if (div_done)
                    state_next = (div_quot == '0) ? ST_DONE : ST_DIV_RATE;
            ST_DIV_RATE:
                if (div_done)
                    state_next = ST_DONE;
            ST_DONE:
                if (out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        s_tready       = state_reg == ST_IDLE;
        ring_cmd.clear = (state_reg == ST_DC) && no_finger;
        ring_cmd.push  = (state_reg == ST_BEAT) && rate_push;
        ring_cmd.data  = dt[IVL_W-1:0];
        div_start      = ((state_reg == ST_SUM) && sum_last)
                      || ((state_reg == ST_DIV_MEAN) && div_done && (div_quot != '0));
        div_dividend   = (state_reg == ST_SUM) ? DIV_W'(sum_add) : RATE_NUMERATOR;
        div_divisor    = (state_reg == ST_SUM) ? DIV_W'(ring_count) : div_quot;
        out_load       = (state_reg == ST_DONE) && out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            finger_thr_reg <= THR_W'(1000);
            amp_thr_reg    <= THR_W'(80);
            min_ivl_reg    <= IVL_W'(333);
            max_ivl_reg    <= IVL_W'(2000);
            dc_reg         <= '0;
            prev_ac_reg    <= '0;
            last_time_reg  <= '0;
            armed_reg      <= 1'b0;
            rate_reg       <= '0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_FINGER_THR: finger_thr_reg <= cfg_data[THR_W-1:0];
                    REG_AMP_THR:    amp_thr_reg    <= cfg_data[THR_W-1:0];
                    REG_MIN_IVL:    min_ivl_reg    <= cfg_data[IVL_W-1:0];
                    REG_MAX_IVL:    max_ivl_reg    <= cfg_data[IVL_W-1:0];
                    default: ;
                endcase
            end
            case (state_reg)
                ST_DC:
                    if (no_finger)
                    begin
                        dc_reg        <= '0;
                        prev_ac_reg   <= '0;
                        last_time_reg <= '0;
                        armed_reg     <= 1'b0;
                        rate_reg      <= '0;
                    end
                    else
                    begin
                        dc_reg <= DC_W'(dc_upd);
                    end
                ST_BEAT:
                begin
                    prev_ac_reg <= ac;
                    if (crossing)
                    begin
                        last_time_reg <= in_time_reg;
                        armed_reg     <= 1'b1;
                    end
                end
                ST_DIV_MEAN:
                    if (div_done && (div_quot == '0))
                        rate_reg <= RATE_NUMERATOR;
                ST_DIV_RATE:
                    if (div_done)
                        rate_reg <= div_quot;
                default: ;
            endcase
            if (out_load)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_ir_reg   <= s_tdata[IR_W-1:0];
            in_time_reg <= s_tdata[IR_W +: TIME_W];
        end
        case (state_reg)
            ST_DC:
            begin
                finger_reg <= !no_finger;
                beat_reg   <= 1'b0;
                upd_reg    <= 1'b0;
                wave_reg   <= '0;
            end
            ST_BEAT:
            begin
                beat_reg <= crossing;
                upd_reg  <= rate_push;
                wave_reg <= wave_calc;
                sum_reg  <= '0;
                k_reg    <= '0;
            end
            ST_SUM:
            begin
                sum_reg <= sum_add;
                k_reg   <= k_reg + 1'b1;
            end
            default: ;
        endcase
        if (out_load)
            m_tdata_reg <= {{(M_DATA_W - 3 - RATE_W - WAVE_W){1'b0}},
                            wave_reg, rate_reg, upd_reg, beat_reg, finger_reg};
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
